// ===== hdl/bfps_pkg.sv =====
// bfps_pkg: shared widths, codes, state and command types for the box fold block
// no dependencies; imported by every module under hdl
`default_nettype none

package bfps_pkg;

    localparam int TIME_W     = 44;
    localparam int DEPTH_W    = 32;
    localparam int UNC_W      = 32;
    localparam int REG_W      = 28;
    localparam int PH_W       = 24;
    localparam int WT_W       = 32;
    localparam int SNR_W      = 32;
    localparam int CNT_OUT_W  = 16;
    localparam int DIV_W      = 64;
    localparam int SQ_W       = 32;
    localparam int HALF_W     = 52;
    localparam int C_W        = 54;
    localparam int OFF_W      = 56;
    localparam int SNRQ_W     = 46;
    localparam int IN_DATA_W  = 136;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;

    localparam logic [REG_W-1:0]     OVERLAP_RST = 28'd58254;
    localparam logic [REG_W-1:0]     STEP_RST    = 28'd58254;
    localparam logic [CNT_OUT_W-1:0] PHASE_LIMIT = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERLAP = 1'b0,
        CFG_STEP    = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_LOAD_PREP,
        OP_LOAD_WR,
        OP_DIV_W,
        OP_IDX_CLR,
        OP_MEM_RD,
        OP_DIV_TMOD,
        OP_DIV_PH,
        OP_DIV_HALF,
        OP_DIV_STEP,
        OP_SWEEP_INIT,
        OP_P1_INIT,
        OP_P1_MUL,
        OP_P1_ACC,
        OP_DIV_MEAN,
        OP_RESC_ONE,
        OP_P2_INIT,
        OP_Z_PREP,
        OP_IDX_INC,
        OP_DIV_Z,
        OP_SQ,
        OP_P2_ACC,
        OP_DIV_CHI,
        OP_SQRT_RESC,
        OP_SQRT_ROOT,
        OP_MULP,
        OP_DIV_SNR,
        OP_DIV_SNRF,
        OP_NEXT,
        OP_OUT_LOAD
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DEC,
        ST_L_CHK,
        ST_L_DIV,
        ST_PH_RD,
        ST_PH_D1,
        ST_PH_D2,
        ST_HALF,
        ST_STEP,
        ST_SWEEP,
        ST_CAND,
        ST_P1_RD,
        ST_P1_MUL,
        ST_P1_ACC,
        ST_P1_END,
        ST_RESC1,
        ST_P2_INIT,
        ST_P2_RD,
        ST_P2_Z,
        ST_P2_DIV,
        ST_P2_SQ,
        ST_P2_ACC,
        ST_CHI,
        ST_RESC,
        ST_MCHK,
        ST_MULP,
        ST_SNR1,
        ST_SNR2,
        ST_NEXT,
        ST_DONE,
        ST_WAIT
    } t_state;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic req_fold;
        logic period_zero;
        logic full;
        logic idx_end;
        logic empty;
        logic n_gt1;
        logic inwin;
        logic mean_pos;
        logic cand_end;
        logic unit_done;
    } t_dp_st;

endpackage

`default_nettype wire

// ===== hdl/bfps_div.sv =====
// bfps_div: 64 by 64 bit unsigned restoring divider, one quotient bit per cycle
// uses bfps_pkg for the operand width
`default_nettype none

module bfps_div (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire [bfps_pkg::DIV_W-1:0] i_a,
    input  wire [bfps_pkg::DIV_W-1:0] i_b,
    output logic                    o_busy,
    output logic                    o_done,
    output logic [bfps_pkg::DIV_W-1:0] o_q,
    output logic [bfps_pkg::DIV_W-1:0] o_r
);
    import bfps_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_q, r_rem, r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DIV_W:0]   rem2;
    logic             ge;

    assign rem2 = {r_rem, r_q[DIV_W-1]};
    assign ge   = rem2 >= {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
                r_q    <= i_a;
                r_b    <= i_b;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= {r_q[DIV_W-2:0], ge};
                r_rem <= ge ? DIV_W'(rem2 - {1'b0, r_b}) : rem2[DIV_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_r    = r_rem;

endmodule

`default_nettype wire

// ===== hdl/bfps_isqrt.sv =====
// bfps_isqrt: 64 bit integer square root, two radicand bits per cycle
// uses bfps_pkg for widths
`default_nettype none

module bfps_isqrt (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire [bfps_pkg::DIV_W-1:0] i_v,
    output logic                      o_done,
    output logic [bfps_pkg::SQ_W-1:0] o_root
);
    import bfps_pkg::*;

    logic [DIV_W-1:0] r_v, r_res, r_bit;
    logic             r_busy, r_done;
    logic [DIV_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_v    <= i_v;
                r_res  <= '0;
                r_bit  <= DIV_W'(1) << (DIV_W - 2);
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == DIV_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[SQ_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/bfps_ctrl.sv =====
// bfps_ctrl: sequencer for load and fold, drives datapath commands
// uses bfps_pkg for state, command and status types
`default_nettype none

module bfps_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output bfps_pkg::t_dp_cmd   o_cmd,
    input  bfps_pkg::t_dp_st    i_st
);
    import bfps_pkg::*;

    t_state r_state, n_state, r_ret, n_ret;
    logic   r_out_valid, n_out_valid;
    t_op    op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_out_valid = r_out_valid & ~i_out_ready;
        op          = OP_NOP;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_CAPTURE;
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                if (!i_st.req_fold) begin
                    op      = OP_LOAD_PREP;
                    n_state = ST_L_CHK;
                end else if (i_st.period_zero) begin
                    op      = OP_SWEEP_INIT;
                    n_state = ST_DONE;
                end else begin
                    op      = OP_IDX_CLR;
                    n_state = ST_PH_RD;
                end
            end
            ST_L_CHK: begin
                if (i_st.full) begin
                    n_state = ST_IDLE;
                end else begin
                    op      = OP_LOAD_WR;
                    n_state = ST_L_DIV;
                end
            end
            ST_L_DIV: begin
                op      = OP_DIV_W;
                n_ret   = ST_IDLE;
                n_state = ST_WAIT;
            end
            ST_PH_RD: begin
                if (i_st.idx_end) begin
                    n_state = ST_HALF;
                end else begin
                    op      = OP_MEM_RD;
                    n_state = ST_PH_D1;
                end
            end
            ST_PH_D1: begin
                op      = OP_DIV_TMOD;
                n_ret   = ST_PH_D2;
                n_state = ST_WAIT;
            end
            ST_PH_D2: begin
                op      = OP_DIV_PH;
                n_ret   = ST_PH_RD;
                n_state = ST_WAIT;
            end
            ST_HALF: begin
                op      = OP_DIV_HALF;
                n_ret   = ST_STEP;
                n_state = ST_WAIT;
            end
            ST_STEP: begin
                op      = OP_DIV_STEP;
                n_ret   = ST_SWEEP;
                n_state = ST_WAIT;
            end
            ST_SWEEP: begin
                op      = OP_SWEEP_INIT;
                n_state = ST_CAND;
            end
            ST_CAND: begin
                if (i_st.cand_end) begin
                    n_state = ST_DONE;
                end else begin
                    op      = OP_P1_INIT;
                    n_state = ST_P1_RD;
                end
            end
            ST_P1_RD: begin
                if (i_st.idx_end) begin
                    n_state = ST_P1_END;
                end else begin
                    op      = OP_MEM_RD;
                    n_state = ST_P1_MUL;
                end
            end
            ST_P1_MUL: begin
                op      = OP_P1_MUL;
                n_state = ST_P1_ACC;
            end
            ST_P1_ACC: begin
                op      = OP_P1_ACC;
                n_state = ST_P1_RD;
            end
            ST_P1_END: begin
                if (i_st.empty) begin
                    n_state = ST_NEXT;
                end else begin
                    op      = OP_DIV_MEAN;
                    n_ret   = i_st.n_gt1 ? ST_P2_INIT : ST_RESC1;
                    n_state = ST_WAIT;
                end
            end
            ST_RESC1: begin
                op      = OP_RESC_ONE;
                n_state = ST_MCHK;
            end
            ST_P2_INIT: begin
                op      = OP_P2_INIT;
                n_state = ST_P2_RD;
            end
            ST_P2_RD: begin
                if (i_st.idx_end) begin
                    n_state = ST_CHI;
                end else begin
                    op      = OP_MEM_RD;
                    n_state = ST_P2_Z;
                end
            end
            ST_P2_Z: begin
                op      = OP_Z_PREP;
                n_state = ST_P2_DIV;
            end
            ST_P2_DIV: begin
                if (!i_st.inwin) begin
                    op      = OP_IDX_INC;
                    n_state = ST_P2_RD;
                end else begin
                    op      = OP_DIV_Z;
                    n_ret   = ST_P2_SQ;
                    n_state = ST_WAIT;
                end
            end
            ST_P2_SQ: begin
                op      = OP_SQ;
                n_state = ST_P2_ACC;
            end
            ST_P2_ACC: begin
                op      = OP_P2_ACC;
                n_state = ST_P2_RD;
            end
            ST_CHI: begin
                op      = OP_DIV_CHI;
                n_ret   = ST_RESC;
                n_state = ST_WAIT;
            end
            ST_RESC: begin
                op      = OP_SQRT_RESC;
                n_ret   = ST_MCHK;
                n_state = ST_WAIT;
            end
            ST_MCHK: begin
                if (!i_st.mean_pos) begin
                    n_state = ST_NEXT;
                end else begin
                    op      = OP_SQRT_ROOT;
                    n_ret   = ST_MULP;
                    n_state = ST_WAIT;
                end
            end
            ST_MULP: begin
                op      = OP_MULP;
                n_state = ST_SNR1;
            end
            ST_SNR1: begin
                op      = OP_DIV_SNR;
                n_ret   = ST_SNR2;
                n_state = ST_WAIT;
            end
            ST_SNR2: begin
                op      = OP_DIV_SNRF;
                n_ret   = ST_NEXT;
                n_state = ST_WAIT;
            end
            ST_NEXT: begin
                op      = OP_NEXT;
                n_state = ST_CAND;
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    op          = OP_OUT_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_WAIT: begin
                if (i_st.unit_done) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd.op    = op;

endmodule

`default_nettype wire

// ===== hdl/bfps_dp.sv =====
// bfps_dp: box stores, accumulators, window test and shared divide/sqrt units
// uses bfps_pkg, bfps_div and bfps_isqrt
`default_nettype none

module bfps_dp #(
    parameter int MAX_BOXES = 4096
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire [bfps_pkg::IN_DATA_W-1:0]     i_in_data,
    input  wire [bfps_pkg::IN_USER_W-1:0]     i_in_user,
    input  wire                               i_cfg_we,
    input  wire [bfps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [bfps_pkg::REG_W-1:0]         i_cfg_data,
    input  bfps_pkg::t_dp_cmd                 i_cmd,
    output bfps_pkg::t_dp_st                  o_st,
    output logic [bfps_pkg::SNR_W-1:0]        o_best_snr,
    output logic [bfps_pkg::CNT_OUT_W-1:0]    o_phase_count
);
    import bfps_pkg::*;

    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int DEN_W = WT_W + CNT_W;

    // configuration and captured item
    logic [REG_W-1:0]   r_overlap, r_step, r_period;
    logic [TIME_W-1:0]  r_in_time;
    logic [DEPTH_W-1:0] r_in_depth;
    logic [UNC_W-1:0]   r_in_unc;
    logic               r_req, r_restart;

    // stores
    logic [TIME_W-1:0]  time_mem  [MAX_BOXES];
    logic [DEPTH_W-1:0] depth_mem [MAX_BOXES];
    logic [UNC_W-1:0]   unc_mem   [MAX_BOXES];
    logic [WT_W-1:0]    wt_mem    [MAX_BOXES];
    logic [PH_W-1:0]    phase_mem [MAX_BOXES];
    logic [TIME_W-1:0]  rd_time;
    logic [DEPTH_W-1:0] rd_depth;
    logic [UNC_W-1:0]   rd_unc;
    logic [WT_W-1:0]    rd_wt;
    logic [PH_W-1:0]    rd_phase;

    logic [CNT_W-1:0]   r_total, r_idx, r_n;
    logic [DIV_W-1:0]   r_uu;
    logic [REG_W-1:0]   r_rem;
    logic [HALF_W-1:0]  r_half, r_stepph;
    logic [C_W-1:0]     r_c;
    logic [CNT_OUT_W-1:0] r_count;
    logic [SNR_W-1:0]   r_best;
    logic signed [DIV_W-1:0] r_num, r_dw;
    logic [DEN_W-1:0]   r_den;
    logic               r_inwin;
    logic signed [DEPTH_W-1:0] r_mean;
    logic [DEPTH_W:0]   r_mag;
    logic [SQ_W-1:0]    r_z, r_resc;
    logic [DIV_W-1:0]   r_sq, r_chi, r_chin, r_prod;
    logic [SQ_W-2:0]    r_root;
    logic [SNRQ_W-1:0]  r_snr_q;
    logic [SQ_W-1:0]    r_snr_r;
    logic [SNR_W-1:0]   r_out_snr;
    logic [CNT_OUT_W-1:0] r_out_cnt;
    t_op                r_tag;

    // unit interfaces
    logic               div_start, div_busy, div_done, sq_start, sq_done;
    logic [DIV_W-1:0]   div_a, div_b, div_q, div_r, sq_v;
    logic [SQ_W-1:0]    sq_root;

    logic [UNC_W-1:0]   in_u, rd_u;
    logic               win;
    logic signed [OFF_W-1:0] off, off_w;
    logic signed [DIV_W:0]   num_sum;
    logic [DIV_W:0]     chi_sum;
    logic signed [DEPTH_W:0] diff;
    logic signed [DEPTH_W:0] wt_s;
    logic signed [2*DEPTH_W+1:0] dw_full;
    logic [DIV_W-1:0]   abs_num, dsh;
    logic [SNRQ_W+4:0]  snr_full;
    logic [IDX_W-1:0]   addr_idx, addr_tot;

    localparam logic signed [DIV_W:0] SAT_P = {2'b00, {(DIV_W-1){1'b1}}};
    localparam logic signed [DIV_W:0] SAT_N = -SAT_P;

    assign addr_idx = r_idx[IDX_W-1:0];
    assign addr_tot = r_total[IDX_W-1:0];
    assign in_u     = (r_in_unc == '0) ? UNC_W'(1) : r_in_unc;
    assign rd_u     = (rd_unc == '0) ? UNC_W'(1) : rd_unc;

    // phase offset below -1/2 folded up by one turn, then tested against the half width
    assign off   = $signed(OFF_W'(rd_phase)) - $signed(OFF_W'(r_c));
    assign off_w = (off < -$signed(OFF_W'(1) << (PH_W - 1))) ?
                   off + $signed(OFF_W'(1) << PH_W) : off;
    assign win   = (off_w > -$signed(OFF_W'(r_half))) && (off_w < $signed(OFF_W'(r_half)));

    assign wt_s    = $signed({1'b0, rd_wt});
    assign dw_full = $signed(rd_depth) * wt_s;
    assign num_sum = $signed({r_num[DIV_W-1], r_num}) + $signed({r_dw[DIV_W-1], r_dw});
    assign chi_sum = {1'b0, r_chi} + {1'b0, r_sq};
    assign diff    = $signed({rd_depth[DEPTH_W-1], rd_depth}) - $signed({r_mean[DEPTH_W-1], r_mean});
    assign abs_num = r_num[DIV_W-1] ? DIV_W'(-r_num) : DIV_W'(r_num);
    assign dsh     = ((DIV_W'(r_den) >> 48) != '0) ? '1 : (DIV_W'(r_den) << 16);
    assign snr_full = {1'b0, r_snr_q, 4'b0} + (SNRQ_W+5)'(div_q[3:0]);

    // operand select for the shared divider
    always_comb begin
        div_start = 1'b1;
        div_a     = '0;
        div_b     = DIV_W'(1);
        case (i_cmd.op)
            OP_DIV_W:    begin div_a = DIV_W'(1) << 40;             div_b = r_uu; end
            OP_DIV_TMOD: begin div_a = DIV_W'(rd_time);             div_b = DIV_W'(r_period); end
            OP_DIV_PH:   begin div_a = DIV_W'({r_rem, {PH_W{1'b0}}}); div_b = DIV_W'(r_period); end
            OP_DIV_HALF: begin div_a = DIV_W'({r_overlap, {PH_W{1'b0}}}); div_b = DIV_W'(r_period); end
            OP_DIV_STEP: begin div_a = DIV_W'({r_step, {PH_W{1'b0}}});    div_b = DIV_W'(r_period); end
            OP_DIV_MEAN: begin div_a = abs_num;                     div_b = DIV_W'(r_den); end
            OP_DIV_Z:    begin div_a = DIV_W'({r_mag, 16'b0});      div_b = DIV_W'(rd_u); end
            OP_DIV_CHI:  begin div_a = r_chi;                       div_b = DIV_W'(r_n - 1'b1); end
            OP_DIV_SNR:  begin div_a = r_prod;                      div_b = DIV_W'(r_resc); end
            OP_DIV_SNRF: begin div_a = DIV_W'({r_snr_r, 4'b0});     div_b = DIV_W'(r_resc); end
            default:     begin div_start = 1'b0; end
        endcase
    end

    assign sq_start = (i_cmd.op == OP_SQRT_RESC) || (i_cmd.op == OP_SQRT_ROOT);
    assign sq_v     = (i_cmd.op == OP_SQRT_RESC) ? r_chin : dsh;

    bfps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (div_a),
        .i_b     (div_b),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_q     (div_q),
        .o_r     (div_r)
    );

    bfps_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_v     (sq_v),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD_WR) begin
            time_mem[addr_tot]  <= r_in_time;
            depth_mem[addr_tot] <= r_in_depth;
            unc_mem[addr_tot]   <= r_in_unc;
        end
        if (i_cmd.op == OP_MEM_RD) begin
            rd_time  <= time_mem[addr_idx];
            rd_depth <= depth_mem[addr_idx];
            rd_unc   <= unc_mem[addr_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_done && r_tag == OP_DIV_W) begin
            wt_mem[addr_tot] <= (div_q[DIV_W-1:WT_W] != '0) ? '1 : div_q[WT_W-1:0];
        end
        if (i_cmd.op == OP_MEM_RD) begin
            rd_wt <= wt_mem[addr_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_done && r_tag == OP_DIV_PH) begin
            phase_mem[addr_idx] <= div_q[PH_W-1:0];
        end
        if (i_cmd.op == OP_MEM_RD) begin
            rd_phase <= phase_mem[addr_idx];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlap <= OVERLAP_RST;
            r_step    <= STEP_RST;
            r_total   <= '0;
            r_idx     <= '0;
            r_tag     <= OP_NOP;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_OVERLAP: r_overlap <= i_cfg_data;
                    CFG_STEP:    r_step    <= i_cfg_data;
                    default:     r_step    <= r_step;
                endcase
            end
            if (div_start || sq_start) begin
                r_tag <= i_cmd.op;
            end
            case (i_cmd.op)
                OP_LOAD_PREP: if (r_restart) r_total <= '0;
                OP_IDX_CLR, OP_P1_INIT, OP_P2_INIT: r_idx <= '0;
                OP_P1_ACC, OP_P2_ACC, OP_IDX_INC:   r_idx <= r_idx + 1'b1;
                default: begin
                    // phase pass moves on once the box phase is stored
                    if (div_done && r_tag == OP_DIV_PH) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            endcase
            if (div_done && r_tag == OP_DIV_W) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_in_time  <= i_in_data[TIME_W-1:0];
                r_in_depth <= i_in_data[TIME_W+DEPTH_W-1:TIME_W];
                r_in_unc   <= i_in_data[TIME_W+DEPTH_W+UNC_W-1:TIME_W+DEPTH_W];
                r_period   <= i_in_data[TIME_W+DEPTH_W+UNC_W+REG_W-1:TIME_W+DEPTH_W+UNC_W];
                r_req      <= i_in_user[0];
                r_restart  <= i_in_user[1];
            end
            OP_LOAD_WR:    r_uu <= DIV_W'(in_u) * DIV_W'(in_u);
            OP_SWEEP_INIT: begin
                r_c     <= C_W'(r_half);
                r_count <= '0;
                r_best  <= '0;
            end
            OP_P1_INIT: begin
                r_num <= '0;
                r_den <= '0;
                r_n   <= '0;
            end
            OP_P1_MUL: begin
                r_dw    <= dw_full[DIV_W-1:0];
                r_inwin <= win;
            end
            OP_P1_ACC: begin
                if (r_inwin) begin
                    if (num_sum > SAT_P) begin
                        r_num <= SAT_P[DIV_W-1:0];
                    end else if (num_sum < SAT_N) begin
                        r_num <= SAT_N[DIV_W-1:0];
                    end else begin
                        r_num <= num_sum[DIV_W-1:0];
                    end
                    r_den <= r_den + DEN_W'(rd_wt);
                    r_n   <= r_n + 1'b1;
                end
            end
            OP_RESC_ONE: r_resc <= SQ_W'(1) << 16;
            OP_P2_INIT:  r_chi  <= '0;
            OP_Z_PREP: begin
                r_inwin <= win;
                r_mag   <= diff[DEPTH_W] ? (DEPTH_W+1)'(-diff) : (DEPTH_W+1)'(diff);
            end
            OP_SQ:     r_sq <= DIV_W'(r_z) * DIV_W'(r_z);
            OP_P2_ACC: r_chi <= chi_sum[DIV_W] ? '1 : chi_sum[DIV_W-1:0];
            OP_MULP:   r_prod <= DIV_W'(r_mean) * DIV_W'(r_root);
            OP_NEXT: begin
                r_c     <= r_c + C_W'(r_stepph);
                r_count <= r_count + 1'b1;
            end
            OP_OUT_LOAD: begin
                r_out_snr <= r_best;
                r_out_cnt <= r_count;
            end
            default: r_c <= r_c;
        endcase

        if (div_done) begin
            case (r_tag)
                OP_DIV_TMOD: r_rem <= div_r[REG_W-1:0];
                OP_DIV_HALF: r_half <= div_q[HALF_W-1:0];
                OP_DIV_STEP: r_stepph <= (div_q == '0) ? HALF_W'(1) : div_q[HALF_W-1:0];
                OP_DIV_MEAN: begin
                    // truncate toward zero, then clamp to the signed 32 bit range
                    if (!r_num[DIV_W-1]) begin
                        r_mean <= (div_q > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                                : div_q[DEPTH_W-1:0];
                    end else begin
                        r_mean <= (div_q > DIV_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                                       : -div_q[DEPTH_W-1:0];
                    end
                end
                OP_DIV_Z:   r_z <= (div_q[DIV_W-1:SQ_W] != '0) ? '1 : div_q[SQ_W-1:0];
                OP_DIV_CHI: r_chin <= (div_q[DIV_W-1:SQ_W] == '0) ? (DIV_W'(1) << SQ_W) : div_q;
                OP_DIV_SNR: begin
                    r_snr_q <= div_q[SNRQ_W-1:0];
                    r_snr_r <= div_r[SQ_W-1:0];
                end
                OP_DIV_SNRF: begin
                    if (snr_full[SNRQ_W+4:SNR_W] != '0) begin
                        r_best <= '1;
                    end else if (snr_full[SNR_W-1:0] > r_best) begin
                        r_best <= snr_full[SNR_W-1:0];
                    end
                end
                default: r_rem <= r_rem;
            endcase
        end
        if (sq_done) begin
            case (r_tag)
                OP_SQRT_RESC: r_resc <= sq_root;
                OP_SQRT_ROOT: r_root <= sq_root[SQ_W-1] ? '1 : sq_root[SQ_W-2:0];
                default:      r_resc <= r_resc;
            endcase
        end
    end

    assign o_st.req_fold    = r_req;
    assign o_st.period_zero = (r_period == '0);
    assign o_st.full        = (r_total == CNT_W'(MAX_BOXES));
    assign o_st.idx_end     = (r_idx == r_total);
    assign o_st.empty       = (r_n == '0) || (r_den == '0);
    assign o_st.n_gt1       = (r_n > CNT_W'(1));
    assign o_st.inwin       = r_inwin;
    assign o_st.mean_pos    = !r_mean[DEPTH_W-1] && (r_mean != '0);
    assign o_st.cand_end    = (r_c > (C_W'(1) << PH_W)) || (r_count == PHASE_LIMIT);
    assign o_st.unit_done   = div_done | sq_done;

    assign o_best_snr    = r_out_snr;
    assign o_phase_count = r_out_cnt;

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_BOXES))
        else $error("box count beyond store depth");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_MEM_RD) |-> (r_idx < r_total))
        else $error("store read past last box");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_done && sq_done))
        else $error("divider and root finished together");

endmodule

`default_nettype wire

// ===== hdl/box_fold_period_snr.sv =====
// box_fold_period_snr: top level, stream ports and configuration write port
// instantiates bfps_ctrl and bfps_dp; uses bfps_pkg
//
// A load beat stores one box (time, depth, uncertainty) and its inverse
// variance weight, formed by the shared divider; a load into a full store is
// dropped. A fold beat with a nonzero trial period computes every box phase
// at the trial period, then sweeps the candidate phases, making one pass over
// all stored boxes to form the weighted mean and, with more than one box in the
// window, a second pass for the chi-square; a fold with a zero period gives a
// zero snr and phase count. One result beat follows each fold, none follows a
// load. All divides share one divider unit and all square roots one root unit.
// The input is taken only between items; a finished result waits in the
// output register while the next item is accepted.
`default_nettype none

module box_fold_period_snr #(
    parameter int MAX_BOXES = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_time[43:0], sample_depth[75:44], sample_uncert[107:76],
    // trial_period[135:108]
    input  wire [135:0] s_axis_tdata,
    // req_type[0], restart_load[1]
    input  wire [1:0]   s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // best_snr[31:0], phase_count[47:32]
    output logic [47:0] m_axis_tdata,
    input  wire         i_cfg_we,
    input  wire [0:0]   i_cfg_index,
    input  wire [27:0]  i_cfg_data
);
    import bfps_pkg::*;

    t_dp_cmd             cmd;
    t_dp_st              st;
    logic [SNR_W-1:0]    best_snr;
    logic [CNT_OUT_W-1:0] phase_count;

    bfps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_st        (st)
    );

    bfps_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_st          (st),
        .o_best_snr    (best_snr),
        .o_phase_count (phase_count)
    );

    assign m_axis_tdata = {phase_count, best_snr};

endmodule

`default_nettype wire

// ===== verif/bfps_tb_pkg.sv =====
// bfps_tb_pkg: request codes and store depth shared by the box fold testbench and its checker
// no dependencies; imported by tb_box_fold_period_snr and bfps_checker
package bfps_tb_pkg;

    typedef enum bit {
        REQ_LOAD = 1'b0,
        REQ_FOLD = 1'b1
    } t_req;

    localparam int TB_MAX_BOXES = 4096;

endpackage

// ===== verif/bfps_checker.sv =====
// bfps_checker: watches the sample, result and register ports of box_fold_period_snr,
// predicts the best fold snr and phase count, and counts mismatches
// depends on bfps_pkg and bfps_tb_pkg
module bfps_checker
    import bfps_pkg::*;
    import bfps_tb_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire [135:0] s_axis_tdata,
    input  wire [1:0]   s_axis_tuser,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire [47:0]  m_axis_tdata,
    input  wire         i_cfg_we,
    input  wire [0:0]   i_cfg_index,
    input  wire [27:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_POS = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint PH_ONE  = 64'sd1 << 24;

    // laid out as the result beat: count on top, snr in the low bits
    typedef struct packed {
        bit [15:0] count;
        bit [31:0] snr;
    } t_fold_result;

    t_fold_result fold_results[$];

    bit [63:0] overlap_reg;
    bit [63:0] step_reg;
    bit [43:0] box_time[TB_MAX_BOXES];
    longint    box_depth[TB_MAX_BOXES];
    bit [63:0] box_unc[TB_MAX_BOXES];
    bit [23:0] box_phase[TB_MAX_BOXES];
    int        box_count;

    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit in_window(int i, longint c, longint half);
        longint off;
        off = longint'(box_phase[i]) - c;
        if (off < -(PH_ONE / 2)) off += PH_ONE;
        return (off > -half) && (off < half);
    endfunction

    function automatic bit [63:0] window_snr(longint c, longint half);
        longint num, den, mean, diff;
        logic signed [64:0] acc;
        int n;
        bit [63:0] w, resc, root, prod, snr, dsh, chi, chin, mag, z, sq;
        num = 0;
        den = 0;
        n = 0;
        resc = 64'd1 << 16;
        for (int i = 0; i < box_count; i++) begin
            if (!in_window(i, c, half)) continue;
            w = (64'd1 << 40) / (box_unc[i] * box_unc[i]);
            if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
            acc = num + box_depth[i] * longint'(w);
            if (acc > SAT_POS) num = SAT_POS;
            else if (acc < -SAT_POS) num = -SAT_POS;
            else num = acc[63:0];
            den += longint'(w);
            n++;
        end
        if (n == 0 || den == 0) return 0;
        mean = num / den;
        if (mean > 64'sd2147483647) mean = 64'sd2147483647;
        if (mean < -64'sd2147483648) mean = -64'sd2147483648;
        if (n > 1) begin
            chi = 0;
            for (int i = 0; i < box_count; i++) begin
                if (!in_window(i, c, half)) continue;
                diff = box_depth[i] - mean;
                mag = (diff < 0) ? -diff : diff;
                z = (mag << 16) / box_unc[i];
                if (z > 64'hFFFF_FFFF) z = 64'hFFFF_FFFF;
                sq = z * z;
                chi = (chi > ~64'd0 - sq) ? ~64'd0 : chi + sq;
            end
            chin = chi / 64'(n - 1);
            if (chin < (64'd1 << 32)) chin = 64'd1 << 32;
            resc = int_sqrt(chin);
        end
        if (mean <= 0) return 0;
        dsh = (den >= (64'sd1 << 48)) ? ~64'd0 : (64'(den) << 16);
        root = int_sqrt(dsh);
        if (root > 64'h7FFF_FFFF) root = 64'h7FFF_FFFF;
        prod = 64'(mean) * root;
        snr = ((prod / resc) << 4) + (((prod % resc) << 4) / resc);
        return (snr > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : snr;
    endfunction

    function automatic t_fold_result fold_at(bit [63:0] period);
        t_fold_result res;
        bit [63:0] best, s, step_ph;
        longint half, c;
        int count;
        res = '0;
        if (period == 0) return res;
        for (int i = 0; i < box_count; i++)
            box_phase[i] = 24'(((64'(box_time[i]) % period) << 24) / period);
        half = longint'((overlap_reg << 24) / period);
        step_ph = (step_reg << 24) / period;
        if (step_ph == 0) step_ph = 1;
        best = 0;
        count = 0;
        for (c = half; c <= PH_ONE && count < 65535; c += longint'(step_ph)) begin
            s = window_snr(c, half);
            if (s > best) best = s;
            count++;
        end
        res.snr = best[31:0];
        res.count = count[15:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_fold_result want, got;
        if (!i_rst_n) begin
            overlap_reg = 64'(OVERLAP_RST);
            step_reg = 64'(STEP_RST);
            box_count = 0;
            fold_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_index) == CFG_OVERLAP) overlap_reg = 64'(i_cfg_data);
                else if (t_cfg_idx'(i_cfg_index) == CFG_STEP) step_reg = 64'(i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (t_req'(s_axis_tuser[0]) == REQ_LOAD) begin
                    if (s_axis_tuser[1]) box_count = 0;
                    if (box_count < TB_MAX_BOXES) begin
                        box_time[box_count] = s_axis_tdata[43:0];
                        box_depth[box_count] = longint'(signed'(s_axis_tdata[75:44]));
                        box_unc[box_count] = (s_axis_tdata[107:76] == 0) ? 64'd1
                                           : 64'(s_axis_tdata[107:76]);
                        box_count++;
                    end
                end else begin
                    fold_results.push_back(fold_at(64'(s_axis_tdata[135:108])));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (fold_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual snr %h count %0d",
                             $realtime, got.snr, got.count);
                    o_fail_count++;
                end else begin
                    want = fold_results.pop_front();
                    if (got.snr !== want.snr) begin
                        $display("%0t: best_snr expected %h actual %h",
                                 $realtime, want.snr, got.snr);
                        o_fail_count++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: phase_count expected %0d actual %0d",
                                 $realtime, want.count, got.count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = fold_results.size();
    end

endmodule

// ===== verif/tb_box_fold_period_snr.sv =====
// tb_box_fold_period_snr: stimulus, stalls and verdict for box_fold_period_snr
// depends on bfps_pkg, bfps_tb_pkg and bfps_checker
module tb_box_fold_period_snr;
    import bfps_pkg::*;
    import bfps_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 40_000_000;
    localparam int SETTLE     = 200;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic [0:0]   i_cfg_index;
    logic [27:0]  i_cfg_data;

    int fail_count;
    int pending;
    int idle_cycles;
    bit calm;
    int stall_left;
    int boxes_held;

    box_fold_period_snr dut (.*);

    bfps_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end else begin
            m_axis_tready = 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_beat(t_req req, bit restart, bit [43:0] t, bit [31:0] depth,
                             bit [31:0] unc, bit [27:0] period);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata = {period, unc, depth, t};
        s_axis_tuser = {restart, bit'(req)};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (req == REQ_LOAD) boxes_held = restart ? 1 : boxes_held + 1;
    endtask

    function automatic bit [43:0] rand_time();
        return {$urandom, $urandom};
    endfunction

    // loads carry noise in the period field, folds in the sample fields
    task automatic load_box(bit restart, bit [43:0] t, bit [31:0] depth, bit [31:0] unc);
        send_beat(REQ_LOAD, restart, t, depth, unc, 28'($urandom));
    endtask

    task automatic fold(bit [27:0] period);
        send_beat(REQ_FOLD, bit'($urandom), rand_time(), $urandom, $urandom, period);
    endtask

    task automatic load_random(bit restart);
        bit [31:0] depth, unc;
        depth = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40000);
        unc = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 20000);
        load_box(restart, rand_time(), depth, unc);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [27:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        int step, ov, items;
        bit [27:0] period;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        calm = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        boxes_held = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty store: phase step rounds to zero, sweep hits the phase cap
        write_reg(CFG_OVERLAP, 28'd0);
        write_reg(CFG_STEP, 28'd1);
        fold(28'hFFF_FFFF);
        fold(28'd0);
        settle();

        // reset defaults, extremes of the sample fields
        write_reg(CFG_OVERLAP, OVERLAP_RST);
        write_reg(CFG_STEP, STEP_RST);
        fold(28'd58254 * 10);
        load_box(1'b1, 44'd0, 32'h7FFF_FFFF, 32'd0);
        load_box(1'b0, 44'hFFF_FFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        load_box(1'b0, 44'd58254 * 3, 32'd30000, 32'd1);
        load_box(1'b0, 44'd58254 * 7, 32'd1000, 32'd500);
        fold(28'd58254 * 10);
        fold(28'd0);
        // single box in window
        load_box(1'b1, 44'd58254, 32'd5000, 32'd100);
        fold(28'd58254 * 8);
        // nonpositive mean
        load_box(1'b1, 44'd58254, 32'hFFFF_0000, 32'd300);
        load_box(1'b0, 44'd58254 * 2, 32'hFFFF_8000, 32'd200);
        load_box(1'b0, 44'd58254 * 4, 32'd10, 32'd9000);
        fold(28'd58254 * 6);
        settle();

        // register maxima: one phase covering the whole cycle
        write_reg(CFG_OVERLAP, 28'hFFF_FFFF);
        write_reg(CFG_STEP, 28'hFFF_FFFF);
        for (int i = 0; i < 5; i++) load_random(i == 0);
        fold(28'hFFF_FFFF);
        settle();

        // random phases: well formed load runs then folds, with some noise
        for (int ph = 0; ph < 5; ph++) begin
            step = $urandom_range(1, 20_000_000) >> $urandom_range(0, 20);
            if (step == 0) step = 1;
            ov = $urandom_range(0, step * 3);
            write_reg(CFG_OVERLAP, 28'(ov));
            write_reg(CFG_STEP, 28'(step));
            items = 0;
            while (items < 16) begin
                calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) != 0 || boxes_held > 12) begin
                    load_random(1'b1);
                    items++;
                end
                repeat ($urandom_range(0, 8)) begin
                    if (boxes_held < 14) begin
                        load_random(1'b0);
                        items++;
                    end
                end
                repeat ($urandom_range(1, 2)) begin
                    period = 28'(step * $urandom_range(2, 12) + $urandom_range(0, step - 1));
                    fold(($urandom_range(0, 15) == 0) ? 28'd0 : period);
                    items++;
                end
            end
            calm = 1'b0;
            settle();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== box_fold_period_snr.f =====
hdl/bfps_pkg.sv
hdl/bfps_div.sv
hdl/bfps_isqrt.sv
hdl/bfps_ctrl.sv
hdl/bfps_dp.sv
hdl/box_fold_period_snr.sv
verif/bfps_tb_pkg.sv
verif/bfps_checker.sv
verif/tb_box_fold_period_snr.sv
